// File: design/lbbt_pkg.sv
// ----------------------------------------------------------------------------
// lbbt_pkg
// Shared types, sizes and helpers for the label bounding-box tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lbbt_pkg;

    // Sizing
    localparam int NUM_BINS  = 10;
    localparam int MAX_DIM   = 1024;
    localparam int LABEL_W   = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int POS_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = POS_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

    // Reciprocal for label mod NUM_BINS: q = (label * REC_M) >> REC_SH
    localparam int REC_SH   = LABEL_W + BIN_W;
    localparam int REC_M    = ((1 << REC_SH) + NUM_BINS - 1) / NUM_BINS;
    localparam int REC_M_W  = LABEL_W + 2;
    localparam int PROD_W   = REC_SH + LABEL_W;

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    // One bin's box
    typedef struct packed {
        logic [POS_W-1:0] max_col;
        logic [DIM_W-1:0] min_col;
        logic [POS_W-1:0] max_row;
        logic [DIM_W-1:0] min_row;
    } bbox_t;

    // Controller to datapath
    typedef struct packed {
        logic             accept;
        logic             load_rec;
        logic [BIN_W-1:0] rec_bin;
    } lbbt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic frame_end;
        logic pipe_busy;
        logic out_free;
    } lbbt_stat_t;

    // Frame size as used: zero reads as one, above MAX_DIM reads as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/lbbt_ctrl.sv
// ----------------------------------------------------------------------------
// lbbt_ctrl
// Sequencer: pixel intake, pipeline flush at frame end, record drain.
// ----------------------------------------------------------------------------
`default_nettype none

module lbbt_ctrl
    import lbbt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire lbbt_stat_t stat,
    output lbbt_cmd_t       cmd
);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [BIN_W-1:0] idx_reg, idx_next;

    // Handshake and commands
    assign s_ready      = (state_reg == ST_RUN);
    assign cmd.accept   = s_valid && s_ready;
    assign cmd.load_rec = (state_reg == ST_DRAIN) && stat.out_free;
    assign cmd.rec_bin  = idx_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_RUN: begin
                if (cmd.accept && stat.frame_end) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_DRAIN;
                    idx_next   = '0;
                end
            end
            ST_DRAIN: begin
                if (cmd.load_rec) begin
                    if (idx_reg == LAST_BIN) begin
                        state_next = ST_RUN;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + BIN_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Last pixel of a frame stops intake until the records are out
    a_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && stat.frame_end) |=> (state_reg == ST_FLUSH))
        else $error("frame end did not start flush");

    // Drain ends after exactly one record per bin
    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_rec && idx_reg == LAST_BIN) |=> (state_reg == ST_RUN && idx_reg == '0))
        else $error("drain did not end on last bin");

    // No intake outside the run state
    a_no_accept_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_RUN) |-> !cmd.accept)
        else $error("pixel taken during flush or drain");

endmodule

`default_nettype wire

// File: design/lbbt_dp.sv
// ----------------------------------------------------------------------------
// lbbt_dp
// Datapath: raster counters, label binning pipe, box store, record register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbbt_dp
    import lbbt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lbbt_cmd_t            cmd,
    output lbbt_stat_t                stat,
    input  wire logic [LABEL_W-1:0]   s_label,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [BIN_W-1:0]          m_bin,
    output logic                      m_valid_res,
    output logic [POS_W-1:0]          m_left_x,
    output logic [POS_W-1:0]          m_top_y,
    output logic [DIM_W-1:0]          m_box_width,
    output logic [DIM_W-1:0]          m_box_height,
    output logic                      m_last
);

    // Configuration registers
    logic [CFG_W-1:0] fw_reg, fh_reg;
    logic [DIM_W-1:0] w, h;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                fw_reg <= cfg_data;
            end
            if (cfg_index == REG_FRAME_HEIGHT) begin
                fh_reg <= cfg_data;
            end
        end
    end

    assign w = clamp_dim(fw_reg);
    assign h = clamp_dim(fh_reg);

    // Raster position of the incoming pixel, with wrap for a shrunk frame
    logic [POS_W-1:0] col_reg, row_reg;
    logic [POS_W-1:0] col_a, row_a, col_next, row_next;
    logic [DIM_W-1:0] row_a1, col_inc, row_inc;
    logic             wrap_a, start_a, col_wrap, row_wrap;

    always_comb begin
        wrap_a   = ({1'b0, col_reg} >= w);
        row_a1   = wrap_a ? ({1'b0, row_reg} + DIM_W'(1)) : {1'b0, row_reg};
        row_a    = (row_a1 >= h) ? '0 : row_a1[POS_W-1:0];
        col_a    = wrap_a ? '0 : col_reg;
        start_a  = (col_a == '0) && (row_a == '0);
        col_inc  = {1'b0, col_a} + DIM_W'(1);
        row_inc  = {1'b0, row_a} + DIM_W'(1);
        col_wrap = (col_inc >= w);
        row_wrap = col_wrap && (row_inc >= h);
        col_next = col_wrap ? '0 : col_inc[POS_W-1:0];
        if (col_wrap) begin
            row_next = row_wrap ? '0 : row_inc[POS_W-1:0];
        end else begin
            row_next = row_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign stat.frame_end = row_wrap;

    // Stage 1: pixel captured
    logic               v1_reg, v2_reg, v3_reg;
    logic [LABEL_W-1:0] s1_label_reg, s2_label_reg;
    logic [POS_W-1:0]   s1_col_reg, s2_col_reg, s3_col_reg;
    logic [POS_W-1:0]   s1_row_reg, s2_row_reg, s3_row_reg;
    logic               s1_start_reg, s2_start_reg, s3_start_reg;
    logic [LABEL_W-1:0] s2_q_reg;
    logic               s3_nz_reg;
    logic [BIN_W-1:0]   s3_bin_reg;
    logic [PROD_W-1:0]  prod;
    logic [LABEL_W-1:0] qn, rem;

    // Quotient by reciprocal multiply, remainder by back-multiply
    assign prod = PROD_W'(s1_label_reg) * PROD_W'(REC_M);
    assign qn   = s2_q_reg * LABEL_W'(NUM_BINS);
    assign rem  = s2_label_reg - qn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_label_reg <= s_label;
        s1_col_reg   <= col_a;
        s1_row_reg   <= row_a;
        s1_start_reg <= start_a;

        s2_label_reg <= s1_label_reg;
        s2_q_reg     <= prod[REC_SH +: LABEL_W];
        s2_col_reg   <= s1_col_reg;
        s2_row_reg   <= s1_row_reg;
        s2_start_reg <= s1_start_reg;

        s3_bin_reg   <= rem[BIN_W-1:0];
        s3_nz_reg    <= (s2_label_reg != '0);
        s3_col_reg   <= s2_col_reg;
        s3_row_reg   <= s2_row_reg;
        s3_start_reg <= s2_start_reg;
    end

    assign stat.pipe_busy = v1_reg || v2_reg || v3_reg;

    // Box store: one read port shared by the update and the drain
    bbox_t            box_reg [NUM_BINS];
    bbox_t            box_next [NUM_BINS];
    bbox_t            cleared, rd_raw, cur, upd;
    logic [BIN_W-1:0] rd_addr;
    logic             clr;

    always_comb begin
        cleared.max_col = '0;
        cleared.min_col = w;
        cleared.max_row = '0;
        cleared.min_row = h;
        rd_addr = cmd.load_rec ? cmd.rec_bin : s3_bin_reg;
        rd_raw  = box_reg[rd_addr];
        clr     = v3_reg && s3_start_reg;
        cur     = clr ? cleared : rd_raw;
        upd     = cur;
        if (s3_col_reg > cur.max_col) begin
            upd.max_col = s3_col_reg;
        end
        if ({1'b0, s3_col_reg} < cur.min_col) begin
            upd.min_col = {1'b0, s3_col_reg};
        end
        if (s3_row_reg > cur.max_row) begin
            upd.max_row = s3_row_reg;
        end
        if ({1'b0, s3_row_reg} < cur.min_row) begin
            upd.min_row = {1'b0, s3_row_reg};
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_BINS; i++) begin
            box_next[i] = box_reg[i];
            if (clr) begin
                box_next[i] = cleared;
            end
            if (v3_reg && s3_nz_reg && (s3_bin_reg == BIN_W'(i))) begin
                box_next[i] = upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_BINS; i++) begin
            box_reg[i] <= box_next[i];
        end
    end

    // Record register
    logic m_valid_reg;
    logic rec_ok;

    assign rec_ok = ({1'b0, rd_raw.max_col} > rd_raw.min_col)
                 && ({1'b0, rd_raw.max_row} > rd_raw.min_row);

    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_rec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_rec) begin
            m_bin       <= cmd.rec_bin;
            m_valid_res <= rec_ok;
            m_last      <= (cmd.rec_bin == LAST_BIN);
            if (rec_ok) begin
                m_left_x     <= rd_raw.min_col[POS_W-1:0];
                m_top_y      <= rd_raw.min_row[POS_W-1:0];
                m_box_width  <= {1'b0, rd_raw.max_col} - rd_raw.min_col;
                m_box_height <= {1'b0, rd_raw.max_row} - rd_raw.min_row;
            end else begin
                m_left_x     <= '0;
                m_top_y      <= '0;
                m_box_width  <= '0;
                m_box_height <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;

    // Drain reads only a settled store
    a_drain_idle_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_rec |-> !stat.pipe_busy)
        else $error("record read while pixel update in flight");

    // A record never overwrites one not yet taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_rec |-> (!m_valid_reg || m_ready))
        else $error("record register overwritten");

    // Drain never overlaps intake
    a_drain_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_rec |-> !cmd.accept)
        else $error("drain and intake overlap");

endmodule

`default_nettype wire

// File: design/label_bounding_box_tracker.sv
// ----------------------------------------------------------------------------
// label_bounding_box_tracker
// Per-bin bounding boxes of a labeled raster, one record per bin per frame.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  s_      | in        | s_valid / s_ready   | label
//  m_      | out       | m_valid / m_ready   | bin, valid_res, left_x, top_y,
//          |           |                     | box_width, box_height, last
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One pixel per cycle while intake is open; each pixel runs a four-stage pipe
//  (capture, reciprocal multiply, remainder, box update) set by the label-to-bin
//  multiply. The last pixel of a frame closes intake: the pipe is flushed, then
//  the drain loads NUM_BINS records at one per cycle unless m_ready stalls.
//  Reset is synchronous; no clearing pass, the box store is loaded at the
//  first pixel of every frame. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module label_bounding_box_tracker
    import lbbt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [LABEL_W-1:0]   s_label,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [BIN_W-1:0]          m_bin,
    output logic                      m_valid_res,
    output logic [POS_W-1:0]          m_left_x,
    output logic [POS_W-1:0]          m_top_y,
    output logic [DIM_W-1:0]          m_box_width,
    output logic [DIM_W-1:0]          m_box_height,
    output logic                      m_last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    lbbt_cmd_t  cmd;
    lbbt_stat_t stat;

    assign cfg_ready = 1'b1;

    lbbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lbbt_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_label      (s_label),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bin        (m_bin),
        .m_valid_res  (m_valid_res),
        .m_left_x     (m_left_x),
        .m_top_y      (m_top_y),
        .m_box_width  (m_box_width),
        .m_box_height (m_box_height),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire
